### design/mtsar_pkg.sv
package mtsar_pkg;

	// Table geometry.
	localparam int DEVICES      = 8;
	localparam int SLOTS        = 10;
	localparam int MAX_REPORTED = 10;
	localparam int CELLS        = DEVICES * SLOTS;

	// Field widths fixed by the item format.
	localparam int DEV_W    = 3;
	localparam int SLOT_W   = 4;
	localparam int COORD_W  = 16;
	localparam int FACTOR_W = 24;

	localparam int CELL_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);
	localparam int LIST_W = $clog2(MAX_REPORTED + 1);

	// Command queue between the front and the back.
	localparam int CMDQ_DEPTH = 4;
	localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
	localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

	// Actions.
	localparam logic [1:0] ACT_RAW  = 2'd0;
	localparam logic [1:0] ACT_DOWN = 2'd1;
	localparam logic [1:0] ACT_MOVE = 2'd2;
	localparam logic [1:0] ACT_UP   = 2'd3;

	// Event types.
	localparam logic [4:0] T_SYN = 5'd0;
	localparam logic [4:0] T_KEY = 5'd1;
	localparam logic [4:0] T_ABS = 5'd3;

	// Event codes.
	localparam logic [9:0] C_SYNC_FRAME      = 10'd0;
	localparam logic [9:0] C_SYN_MT_REPORT   = 10'd2;
	localparam logic [9:0] C_ABS_X           = 10'd0;
	localparam logic [9:0] C_ABS_Y           = 10'd1;
	localparam logic [9:0] C_MT_SLOT         = 10'd47;
	localparam logic [9:0] C_MT_TOUCH_MAJOR  = 10'd48;
	localparam logic [9:0] C_MT_TOUCH_MINOR  = 10'd49;
	localparam logic [9:0] C_MT_WIDTH_MAJOR  = 10'd50;
	localparam logic [9:0] C_MT_POS_X        = 10'd53;
	localparam logic [9:0] C_MT_POS_Y        = 10'd54;
	localparam logic [9:0] C_MT_TRACK        = 10'd57;
	localparam logic [9:0] C_BTN_TOOL_FINGER = 10'd325;
	localparam logic [9:0] C_BTN_TOUCH       = 10'd330;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SCALE_X      = 2'd0;
	localparam logic [1:0] CFG_SCALE_Y      = 2'd1;
	localparam logic [1:0] CFG_INJECT_SCALE = 2'd2;

	localparam logic [FACTOR_W-1:0] SCALE_ONE = 24'd65536;

	typedef struct packed {
		logic [1:0]          action;
		logic [DEV_W-1:0]    device;
		logic [4:0]          ev_type;
		logic [9:0]          ev_code;
		logic signed [31:0]  ev_value;
		logic [SLOT_W-1:0]   slot;
		logic [COORD_W-1:0]  pos_x;
		logic [COORD_W-1:0]  pos_y;
	} mt_item_t;

	typedef struct packed {
		logic [4:0]         out_type;
		logic [9:0]         out_code;
		logic signed [31:0] out_value;
		logic               last;
	} mt_event_t;

	typedef struct packed {
		logic [FACTOR_W-1:0] scale_x;
		logic [FACTOR_W-1:0] scale_y;
		logic [FACTOR_W-1:0] inject_scale;
	} mt_scale_t;

	// One table operation, optionally followed by a report.
	typedef struct packed {
		logic [CELL_W-1:0]  entry;
		logic               wr_x;
		logic               wr_y;
		logic               set_down;
		logic               clr_down;
		logic               report;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} mt_cmd_t;

endpackage

### design/mtsar_front.sv
module mtsar_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtsar_pkg::mt_scale_t scale,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  mtsar_pkg::mt_item_t  src_data,
	output logic                 push_valid,
	input  logic                 push_ready,
	output mtsar_pkg::mt_cmd_t   push_data
);
	import mtsar_pkg::*;

	localparam int MAG_W  = 31;
	localparam int PROD_W = MAG_W + FACTOR_W;

	function automatic logic [CELL_W-1:0] cell_of(logic [DEV_W-1:0] dev,
			logic [SLOT_W-1:0] slt);
		logic [7:0] t;
		t = 8'(dev) * 8'(SLOTS) + 8'(slt);
		return CELL_W'(t);
	endfunction

	function automatic logic [COORD_W-1:0] sat16(logic [PROD_W-1:0] p, logic zero);
		if (zero)
			return '0;
		else if (|p[PROD_W-1:32])
			return '1;
		else
			return p[31:16];
	endfunction

	logic [SLOT_W-1:0] cur_slot_q [DEVICES];
	logic [CELLS-1:0]  touched_q;

	// Decode results.
	mt_cmd_t             dc_cmd;
	logic                dc_keep;
	logic [MAG_W-1:0]    dc_ax, dc_ay;
	logic                dc_zx, dc_zy;
	logic [FACTOR_W-1:0] dc_fx, dc_fy;
	logic                dc_slot_we, dc_touch_we;
	logic [SLOT_W-1:0]   cur;
	logic                dev_ok;

	// Pipeline.
	logic                valid_s1, valid_s2;
	mt_cmd_t             cmd_s1, cmd_s2;
	logic [MAG_W-1:0]    ax_s1, ay_s1;
	logic                zx_s1, zy_s1, zx_s2, zy_s2;
	logic [FACTOR_W-1:0] fx_s1, fy_s1;
	logic [PROD_W-1:0]   px_s2, py_s2;
	logic                accept, s2_free, s1_free;

	assign s2_free   = !valid_s2 || push_ready;
	assign s1_free   = !valid_s1 || s2_free;
	assign src_ready = s1_free;
	assign accept    = src_valid && src_ready;

	assign dev_ok = {1'b0, src_data.device} < 4'(DEVICES);

	always_comb begin
		dc_cmd      = '0;
		dc_keep     = 1'b0;
		dc_ax       = '0;
		dc_ay       = '0;
		dc_zx       = 1'b1;
		dc_zy       = 1'b1;
		dc_fx       = scale.inject_scale;
		dc_fy       = scale.inject_scale;
		dc_slot_we  = 1'b0;
		dc_touch_we = 1'b0;
		cur         = cur_slot_q[src_data.device];
		if ({1'b0, cur} >= 5'(SLOTS))
			cur = '0;
		if (src_data.action != ACT_RAW) begin
			dc_cmd.entry = cell_of(src_data.device, src_data.slot);
			dc_keep     = dev_ok && ({1'b0, src_data.slot} < 5'(SLOTS));
			dc_cmd.report = 1'b1;
			if (src_data.action == ACT_UP) begin
				dc_cmd.clr_down = 1'b1;
			end else begin
				dc_cmd.set_down = 1'b1;
				// A down with a zero factor keeps the stored position.
				dc_cmd.wr_x = (src_data.action == ACT_MOVE) || (scale.inject_scale != '0);
				dc_cmd.wr_y = dc_cmd.wr_x;
				dc_ax = MAG_W'(src_data.pos_x);
				dc_ay = MAG_W'(src_data.pos_y);
				dc_zx = 1'b0;
				dc_zy = 1'b0;
			end
		end else begin
			dc_cmd.entry = cell_of(src_data.device, cur);
			if (src_data.ev_type == T_ABS) begin
				case (src_data.ev_code)
					C_MT_SLOT: begin
						dc_slot_we = dev_ok && !src_data.ev_value[31]
							&& (src_data.ev_value[30:0] < 31'(SLOTS));
					end
					C_MT_TRACK: begin
						dc_keep = dev_ok;
						if (src_data.ev_value == -32'sd1)
							dc_cmd.clr_down = 1'b1;
						else
							dc_cmd.set_down = 1'b1;
					end
					C_MT_POS_X: begin
						dc_keep     = dev_ok;
						dc_touch_we = dev_ok;
						dc_cmd.wr_x = 1'b1;
						dc_ax       = src_data.ev_value[30:0];
						dc_zx       = src_data.ev_value[31];
						dc_fx       = scale.scale_x;
					end
					C_MT_POS_Y: begin
						dc_keep     = dev_ok;
						dc_touch_we = dev_ok;
						dc_cmd.wr_y = 1'b1;
						dc_ay       = src_data.ev_value[30:0];
						dc_zy       = src_data.ev_value[31];
						dc_fy       = scale.scale_y;
					end
					C_MT_TOUCH_MAJOR, C_MT_TOUCH_MINOR, C_MT_WIDTH_MAJOR: begin
						dc_touch_we = dev_ok;
					end
					default: begin
					end
				endcase
			end else if (src_data.ev_type == T_SYN && src_data.ev_code == C_SYNC_FRAME) begin
				dc_keep       = dev_ok && touched_q[dc_cmd.entry];
				dc_cmd.report = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DEVICES; d++)
				cur_slot_q[d] <= '0;
			touched_q <= '0;
		end else if (accept) begin
			if (dc_slot_we)
				cur_slot_q[src_data.device] <= src_data.ev_value[SLOT_W-1:0];
			if (dc_touch_we)
				touched_q[dc_cmd.entry] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= accept && dc_keep;
			if (s2_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && accept) begin
			cmd_s1 <= dc_cmd;
			ax_s1  <= dc_ax;
			ay_s1  <= dc_ay;
			zx_s1  <= dc_zx || (dc_ax == '0);
			zy_s1  <= dc_zy || (dc_ay == '0);
			fx_s1  <= dc_fx;
			fy_s1  <= dc_fy;
		end
		if (s2_free && valid_s1) begin
			cmd_s2 <= cmd_s1;
			px_s2  <= PROD_W'(ax_s1) * PROD_W'(fx_s1);
			py_s2  <= PROD_W'(ay_s1) * PROD_W'(fy_s1);
			zx_s2  <= zx_s1;
			zy_s2  <= zy_s1;
		end
	end

	always_comb begin
		push_data   = cmd_s2;
		push_data.x = sat16(px_s2, zx_s2);
		push_data.y = sat16(py_s2, zy_s2);
	end

	assign push_valid = valid_s2;

endmodule

### design/mtsar_cmd_fifo.sv
module mtsar_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  mtsar_pkg::mt_cmd_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output mtsar_pkg::mt_cmd_t pop_data
);
	import mtsar_pkg::*;

	mt_cmd_t           entry_q [CMDQ_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != QCNT_W'(CMDQ_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

### design/mtsar_back.sv
module mtsar_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  mtsar_pkg::mt_cmd_t   pop_data,
	output logic                 rpt_valid,
	input  logic                 rpt_ready,
	output mtsar_pkg::mt_event_t rpt_data
);
	import mtsar_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_KEY_ON_T, ST_KEY_ON_F, ST_SCAN, ST_EMIT,
		ST_NOF_MT, ST_KEY_OFF_T, ST_KEY_OFF_F, ST_SYNC
	} state_t;

	typedef enum logic [2:0] {
		F_X, F_Y, F_MT_X, F_MT_Y, F_ID, F_MT_REPORT
	} fstep_t;

	function automatic logic [7:0] make_id(logic [DEV_W-1:0] dev, logic [SLOT_W-1:0] slt);
		logic [9:0] t;
		t = ({6'd0, dev, 1'b1}) * 10'(SLOTS) + 10'(slt);
		return t[7:0];
	endfunction

	function automatic mt_event_t ev(logic [4:0] t, logic [9:0] c, logic [31:0] v,
			logic l);
		mt_event_t e;
		e.out_type  = t;
		e.out_code  = c;
		e.out_value = v;
		e.last      = l;
		return e;
	endfunction

	state_t            state_q;
	fstep_t            step_q;
	logic [CELLS-1:0]  down_q, vx_q, vy_q;
	logic [CNT_W-1:0]  down_cnt_q;
	logic              pending_q;
	logic [CNT_W-1:0]  idx_q;
	logic [DEV_W-1:0]  row_q;
	logic [SLOT_W-1:0] col_q;
	logic [LIST_W-1:0] listed_q;
	logic              has_x_q, has_y_q;
	logic              out_valid_q;
	mt_event_t         out_q;

	logic [COORD_W-1:0] x_mem [CELLS];
	logic [COORD_W-1:0] y_mem [CELLS];
	logic [COORD_W-1:0] rd_x_q, rd_y_q;

	logic               apply, out_free, out_load, scan_end, rd_en, was_down;
	logic [CELL_W-1:0]  idx_cell;
	logic [31:0]        x_val, y_val;

	assign pop_ready = state_q == ST_IDLE;
	assign apply     = pop_valid && pop_ready;
	assign out_free  = !out_valid_q || rpt_ready;
	// The output register takes a new event in this cycle.
	assign out_load  = out_free && (state_q inside {ST_KEY_ON_T, ST_KEY_ON_F, ST_EMIT,
		ST_NOF_MT, ST_KEY_OFF_T, ST_KEY_OFF_F, ST_SYNC});
	assign idx_cell  = idx_q[CELL_W-1:0];
	assign scan_end  = (idx_q == CNT_W'(CELLS)) || (listed_q == LIST_W'(MAX_REPORTED));
	assign rd_en     = (state_q == ST_SCAN) && !scan_end && down_q[idx_cell];
	assign was_down  = down_q[pop_data.entry];
	assign x_val     = has_x_q ? 32'(rd_x_q) : '0;
	assign y_val     = has_y_q ? 32'(rd_y_q) : '0;
	assign rpt_valid = out_valid_q;
	assign rpt_data  = out_q;

	always_ff @(posedge clk) begin
		if (apply && pop_data.wr_x)
			x_mem[pop_data.entry] <= pop_data.x;
		if (apply && pop_data.wr_y)
			y_mem[pop_data.entry] <= pop_data.y;
		if (rd_en) begin
			rd_x_q <= x_mem[idx_cell];
			rd_y_q <= y_mem[idx_cell];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= F_X;
			down_q      <= '0;
			vx_q        <= '0;
			vy_q        <= '0;
			down_cnt_q  <= '0;
			pending_q   <= 1'b1;
			idx_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			listed_q    <= '0;
			has_x_q     <= 1'b0;
			has_y_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && rpt_ready && !out_load)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (apply) begin
						if (pop_data.wr_x)
							vx_q[pop_data.entry] <= 1'b1;
						if (pop_data.wr_y)
							vy_q[pop_data.entry] <= 1'b1;
						if (pop_data.set_down) begin
							down_q[pop_data.entry] <= 1'b1;
							if (!was_down)
								down_cnt_q <= down_cnt_q + 1'b1;
						end else if (pop_data.clr_down) begin
							down_q[pop_data.entry] <= 1'b0;
							if (was_down)
								down_cnt_q <= down_cnt_q - 1'b1;
						end
						if (pop_data.report) begin
							idx_q    <= '0;
							row_q    <= '0;
							col_q    <= '0;
							listed_q <= '0;
							state_q  <= ST_START;
						end
					end
				end
				ST_START: begin
					if (down_cnt_q != '0 && pending_q) begin
						pending_q <= 1'b0;
						state_q   <= ST_KEY_ON_T;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_KEY_ON_T: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= ev(T_KEY, C_BTN_TOUCH, 32'd1, 1'b0);
						state_q     <= ST_KEY_ON_F;
					end
				end
				ST_KEY_ON_F: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= ev(T_KEY, C_BTN_TOOL_FINGER, 32'd1, 1'b0);
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= (down_cnt_q == '0) ? ST_NOF_MT : ST_SYNC;
					end else if (down_q[idx_cell]) begin
						has_x_q <= vx_q[idx_cell];
						has_y_q <= vy_q[idx_cell];
						step_q  <= F_X;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (col_q == SLOT_W'(SLOTS - 1)) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						case (step_q)
							F_X: begin
								out_q  <= ev(T_ABS, C_ABS_X, x_val, 1'b0);
								step_q <= F_Y;
							end
							F_Y: begin
								out_q  <= ev(T_ABS, C_ABS_Y, y_val, 1'b0);
								step_q <= F_MT_X;
							end
							F_MT_X: begin
								out_q  <= ev(T_ABS, C_MT_POS_X, x_val, 1'b0);
								step_q <= F_MT_Y;
							end
							F_MT_Y: begin
								out_q  <= ev(T_ABS, C_MT_POS_Y, y_val, 1'b0);
								step_q <= F_ID;
							end
							F_ID: begin
								out_q  <= ev(T_ABS, C_MT_TRACK, 32'(make_id(row_q, col_q)), 1'b0);
								step_q <= F_MT_REPORT;
							end
							default: begin
								out_q    <= ev(T_SYN, C_SYN_MT_REPORT, 32'd0, 1'b0);
								step_q   <= F_X;
								listed_q <= listed_q + 1'b1;
								idx_q    <= idx_q + 1'b1;
								if (col_q == SLOT_W'(SLOTS - 1)) begin
									col_q <= '0;
									row_q <= row_q + 1'b1;
								end else begin
									col_q <= col_q + 1'b1;
								end
								state_q <= ST_SCAN;
							end
						endcase
					end
				end
				ST_NOF_MT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= ev(T_SYN, C_SYN_MT_REPORT, 32'd0, 1'b0);
						if (!pending_q) begin
							pending_q <= 1'b1;
							state_q   <= ST_KEY_OFF_T;
						end else begin
							state_q <= ST_SYNC;
						end
					end
				end
				ST_KEY_OFF_T: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= ev(T_KEY, C_BTN_TOUCH, 32'd0, 1'b0);
						state_q     <= ST_KEY_OFF_F;
					end
				end
				ST_KEY_OFF_F: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= ev(T_KEY, C_BTN_TOOL_FINGER, 32'd0, 1'b0);
						state_q     <= ST_SYNC;
					end
				end
				ST_SYNC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= ev(T_SYN, C_SYNC_FRAME, 32'd0, 1'b1);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/multitouch_slot_to_anonymous_report.sv
// Converts slotted multitouch input into anonymous-contact reports.
// The src channel takes one item per transfer: a raw event from a source
// device or an injected down, move or up for a slot. The rpt channel gives
// one output event per transfer; the closing frame sync of a report has last
// set. Scale registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle, as the block does
// not enforce it. A write to an index beyond the list is dropped. The front
// decodes an item into stage s1, scales its coordinates into stage s2 and
// enters a command in a four-deep queue. An item that edits the table and
// causes no report sustains one transfer per cycle while the queue has room.
// The back applies a command and takes no other until its report, if any,
// is done; a report walks the finger table one empty entry per cycle, emits
// six events per listed finger into an output register that sends one per cycle.
// When the receiver stalls, the output register holds its event, the back
// waits, and the queue and front keep taking items until they are full.
// Reset clears the finger table and slot state at once through per-entry flag
// bits, so there is no clearing pass, and loads every scale factor with 1.0.
module multitouch_slot_to_anonymous_report (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  mtsar_pkg::mt_item_t  src_data,
	output logic                 rpt_valid,
	input  logic                 rpt_ready,
	output mtsar_pkg::mt_event_t rpt_data
);
	import mtsar_pkg::*;

	// Q8.16 scale factors.
	mt_scale_t scale_q;

	// Commands from the front to the queue, and from the queue to the back.
	logic    push_valid, push_ready, pop_valid, pop_ready;
	mt_cmd_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q.scale_x      <= SCALE_ONE;
			scale_q.scale_y      <= SCALE_ONE;
			scale_q.inject_scale <= SCALE_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE_X:      scale_q.scale_x      <= cfg_data;
				CFG_SCALE_Y:      scale_q.scale_y      <= cfg_data;
				CFG_INJECT_SCALE: scale_q.inject_scale <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front owns the per-device current slot and the touched flags, so it
	// settles other raw events itself and forwards only table edits and reports.
	mtsar_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.scale      (scale_q),
		.src_valid  (src_valid),
		.src_ready  (src_ready),
		.src_data   (src_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mtsar_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The back holds positions and down flags and builds each report in
	// command order, so a report always sees every earlier edit.
	mtsar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt_data  (rpt_data)
	);

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the multitouch slot-to-report converter.
// Every item that completes a transfer on the src channel goes through a
// behavioral copy of the finger table. Each report that copy produces is
// queued event by event. The checker then compares each rpt transfer, field
// by field, against the oldest queued event.
module testbench;
	import mtsar_pkg::*;

	// Longest quiet spell of a correct run is one full table walk plus a long
	// receiver stall.
	localparam int STALL_LIMIT   = 4000;
	// This settle time covers a full report walk.
	localparam int SETTLE_CYCLES = 200;
	localparam int MAX_PRINTS    = 40;
	// This index is not in the register list, so the block must drop the write.
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = CFG_SCALE_X;
	logic [23:0] cfg_data  = '0;
	logic        src_valid = 1'b0;
	logic        src_ready;
	mt_item_t    src_data  = '0;
	logic        rpt_valid;
	logic        rpt_ready = 1'b0;
	mt_event_t   rpt_data;

	multitouch_slot_to_anonymous_report dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt_data  (rpt_data)
	);

	// This is the bench's own copy of the finger table and scale registers.
	logic [15:0]         pos_x_tab [CELLS];
	logic [15:0]         pos_y_tab [CELLS];
	logic [7:0]          id_tab    [CELLS];
	bit                  down_tab  [CELLS];
	bit                  touch_tab [CELLS];
	logic [SLOT_W-1:0]   cur_slot  [DEVICES];
	bit                  touch_pending = 1'b1;
	logic [FACTOR_W-1:0] k_x   = SCALE_ONE;
	logic [FACTOR_W-1:0] k_y   = SCALE_ONE;
	logic [FACTOR_W-1:0] k_inj = SCALE_ONE;

	mt_event_t expected_events[$];
	int        errors       = 0;
	int        live_items   = 0;
	int        src_idle_pct = 0;
	int        rcv_idle_pct = 0;
	int        quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Multiply by a Q8.16 factor and truncate. Negative inputs give zero, and
	// the result clamps to the 16-bit range.
	function automatic logic [15:0] sat_scale(input longint v, input logic [23:0] f);
		longint p;
		if (v <= 0)
			return 16'd0;
		p = (v * longint'(f)) >>> 16;
		return (p > 65535) ? 16'hFFFF : p[15:0];
	endfunction

	function automatic logic [7:0] touch_id(input int dev, input int slot);
		return 8'((dev * 2 + 1) * SLOTS + slot);
	endfunction

	function automatic mt_event_t report_event(input logic [4:0] t, input logic [9:0] code,
			input logic [31:0] v, input logic l);
		mt_event_t e;
		e.out_type  = t;
		e.out_code  = code;
		e.out_value = v;
		e.last      = l;
		return e;
	endfunction

	// The report lists the first MAX_REPORTED down fingers in row-then-slot
	// order. Touch-button edges are added on the first finger down and again
	// when the last finger lifts.
	function automatic void queue_report();
		bit any;
		int listed;
		int i;
		any    = 1'b0;
		listed = 0;
		for (i = 0; i < CELLS; i++)
			if (down_tab[i])
				any = 1'b1;
		if (any && touch_pending) begin
			touch_pending = 1'b0;
			expected_events.push_back(report_event(T_KEY, C_BTN_TOUCH, 1, 1'b0));
			expected_events.push_back(report_event(T_KEY, C_BTN_TOOL_FINGER, 1, 1'b0));
		end
		for (i = 0; i < CELLS && listed < MAX_REPORTED; i++) begin
			if (down_tab[i]) begin
				listed++;
				expected_events.push_back(report_event(T_ABS, C_ABS_X,
					32'(pos_x_tab[i]), 1'b0));
				expected_events.push_back(report_event(T_ABS, C_ABS_Y,
					32'(pos_y_tab[i]), 1'b0));
				expected_events.push_back(report_event(T_ABS, C_MT_POS_X,
					32'(pos_x_tab[i]), 1'b0));
				expected_events.push_back(report_event(T_ABS, C_MT_POS_Y,
					32'(pos_y_tab[i]), 1'b0));
				expected_events.push_back(report_event(T_ABS, C_MT_TRACK,
					32'(id_tab[i]), 1'b0));
				expected_events.push_back(report_event(T_SYN, C_SYN_MT_REPORT, 0, 1'b0));
			end
		end
		if (!any) begin
			expected_events.push_back(report_event(T_SYN, C_SYN_MT_REPORT, 0, 1'b0));
			if (!touch_pending) begin
				touch_pending = 1'b1;
				expected_events.push_back(report_event(T_KEY, C_BTN_TOUCH, 0, 1'b0));
				expected_events.push_back(report_event(T_KEY, C_BTN_TOOL_FINGER, 0, 1'b0));
			end
		end
		expected_events.push_back(report_event(T_SYN, C_SYNC_FRAME, 0, 1'b1));
	endfunction

	// Apply one accepted item to the table copy and queue any report it causes.
	// The return value is 1 when the item had an effect, and 0 when the block
	// is expected to ignore it.
	function automatic bit apply_touch_item(input mt_item_t it);
		int dev;
		int cur;
		int ent;
		logic signed [31:0] val;
		dev = int'(it.device);
		val = it.ev_value;
		if (dev >= DEVICES)
			return 1'b0;
		if (it.action != ACT_RAW) begin
			if (it.slot >= SLOTS)
				return 1'b0;
			ent = dev * SLOTS + int'(it.slot);
			if (it.action == ACT_UP) begin
				down_tab[ent] = 1'b0;
			end else begin
				id_tab[ent] = touch_id(dev, int'(it.slot));
				// With a zero inject scale, a down keeps the old position.
				if (it.action == ACT_MOVE || k_inj != 0) begin
					pos_x_tab[ent] = sat_scale(longint'(it.pos_x), k_inj);
					pos_y_tab[ent] = sat_scale(longint'(it.pos_y), k_inj);
				end
				down_tab[ent] = 1'b1;
			end
			queue_report();
			return 1'b1;
		end
		cur = int'(cur_slot[dev]);
		if (cur >= SLOTS)
			cur = 0;
		ent = dev * SLOTS + cur;
		if (it.ev_type == T_ABS) begin
			case (it.ev_code)
				C_MT_SLOT: begin
					if (val < 0 || val >= SLOTS)
						return 1'b0;
					cur_slot[dev] = val[SLOT_W-1:0];
				end
				C_MT_TRACK: begin
					if (val == -1) begin
						down_tab[ent] = 1'b0;
					end else begin
						id_tab[ent]   = touch_id(dev, cur);
						down_tab[ent] = 1'b1;
					end
				end
				C_MT_POS_X: begin
					id_tab[ent]    = touch_id(dev, cur);
					pos_x_tab[ent] = sat_scale(longint'(val), k_x);
					touch_tab[ent] = 1'b1;
				end
				C_MT_POS_Y: begin
					id_tab[ent]    = touch_id(dev, cur);
					pos_y_tab[ent] = sat_scale(longint'(val), k_y);
					touch_tab[ent] = 1'b1;
				end
				C_MT_TOUCH_MAJOR, C_MT_TOUCH_MINOR, C_MT_WIDTH_MAJOR: begin
					id_tab[ent]    = touch_id(dev, cur);
					touch_tab[ent] = 1'b1;
				end
				default: return 1'b0;
			endcase
			return 1'b1;
		end
		// A source frame sync reports only once its current slot has been touched.
		if (it.ev_type == T_SYN && it.ev_code == C_SYNC_FRAME && touch_tab[ent]) begin
			queue_report();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Build an item with every field random, so that the fields an item does
	// not use still toggle.
	function automatic mt_item_t rand_item();
		mt_item_t it;
		it.action   = 2'($urandom_range(0, 3));
		it.device   = 3'($urandom_range(0, 7));
		it.ev_type  = 5'($urandom_range(0, 31));
		it.ev_code  = 10'($urandom_range(0, 1023));
		it.ev_value = $urandom();
		it.slot     = 4'($urandom_range(0, 15));
		it.pos_x    = 16'($urandom_range(0, 65535));
		it.pos_y    = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic mt_item_t raw_event(input int dev, input logic [4:0] t,
			input logic [9:0] code, input logic [31:0] value);
		mt_item_t it;
		it          = rand_item();
		it.action   = ACT_RAW;
		it.device   = 3'(dev);
		it.ev_type  = t;
		it.ev_code  = code;
		it.ev_value = value;
		return it;
	endfunction

	function automatic mt_item_t inject_item(input logic [1:0] act, input int dev,
			input int slot, input logic [15:0] x, input logic [15:0] y);
		mt_item_t it;
		it        = rand_item();
		it.action = act;
		it.device = 3'(dev);
		it.slot   = 4'(slot);
		it.pos_x  = x;
		it.pos_y  = y;
		return it;
	endfunction

	// Present one item and hold it until it is accepted. Valid is left high
	// when the task returns, so the caller either sends the next item at
	// once or lowers valid in that same time step.
	task automatic send_item(input mt_item_t it);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		src_valid <= 1'b1;
		src_data  <= it;
		do @(posedge clk); while (!src_ready);
		if (apply_touch_item(it))
			live_items++;
	endtask

	// Stop sending, wait for every queued event to be seen, and then give
	// the block time to finish any item that causes no report.
	task automatic wait_quiet();
		src_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three scale registers on back-to-back cycles, and then write
	// the unused index, which the block must ignore.
	task automatic load_scales(input logic [23:0] sx, input logic [23:0] sy,
			input logic [23:0] si);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCALE_X;
		cfg_data  <= sx;
		@(posedge clk);
		cfg_index <= CFG_SCALE_Y;
		cfg_data  <= sy;
		@(posedge clk);
		cfg_index <= CFG_INJECT_SCALE;
		cfg_data  <= si;
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data  <= 24'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		k_x   = sx;
		k_y   = sy;
		k_inj = si;
	endtask

	// Random traffic. Most of it is well-formed slotted frames and injections
	// with random content, and the rest is noise. Only items that have an
	// effect count toward n.
	task automatic run_random(input int n);
		int target;
		int dev;
		int pick;
		mt_item_t it;
		target = live_items + n;
		while (live_items < target) begin
			pick = $urandom_range(0, 99);
			dev  = $urandom_range(0, DEVICES - 1);
			if (pick < 45) begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 99) < 80)
						send_item(raw_event(dev, T_ABS, C_MT_SLOT,
							($urandom_range(0, 99) < 85) ?
							32'($urandom_range(0, SLOTS - 1)) : $urandom()));
					if ($urandom_range(0, 99) < 80)
						send_item(raw_event(dev, T_ABS, C_MT_TRACK,
							($urandom_range(0, 99) < 80) ?
							32'($urandom_range(0, 65535)) : 32'hFFFF_FFFF));
					if ($urandom_range(0, 99) < 75)
						send_item(raw_event(dev, T_ABS, C_MT_POS_X,
							($urandom_range(0, 99) < 80) ?
							32'($urandom_range(0, 4095)) : $urandom()));
					if ($urandom_range(0, 99) < 75)
						send_item(raw_event(dev, T_ABS, C_MT_POS_Y,
							($urandom_range(0, 99) < 80) ?
							32'($urandom_range(0, 4095)) : $urandom()));
					if ($urandom_range(0, 99) < 30)
						send_item(raw_event(dev, T_ABS,
							C_MT_TOUCH_MAJOR + 10'($urandom_range(0, 2)), $urandom()));
				end
				if ($urandom_range(0, 99) < 90)
					send_item(raw_event(dev, T_SYN, C_SYNC_FRAME, $urandom()));
			end else if (pick < 88) begin
				it        = rand_item();
				it.device = 3'(dev);
				pick      = $urandom_range(0, 99);
				it.action = (pick < 50) ? ACT_DOWN : (pick < 70) ? ACT_MOVE : ACT_UP;
				if ($urandom_range(0, 99) < 90)
					it.slot = 4'($urandom_range(0, SLOTS - 1));
				send_item(it);
			end else begin
				it = rand_item();
				if ($urandom_range(0, 99) < 50)
					it.action = ACT_RAW;
				send_item(it);
			end
		end
	endtask

	// Slotted source frames at the reset scale. This covers the slot select
	// and its out-of-range values, the clamp of negative and huge positions,
	// ignored types and codes, a frame sync on an untouched slot, contact
	// sizes, and the touch-button edges at both ends.
	task automatic test_raw_frames();
		send_item(raw_event(0, T_SYN, C_SYNC_FRAME, 0));
		send_item(raw_event(0, T_ABS, C_MT_SLOT, 3));
		send_item(raw_event(0, T_ABS, C_MT_SLOT, 32'hFFFF_FFFF));
		send_item(raw_event(0, T_ABS, C_MT_SLOT, SLOTS));
		send_item(raw_event(0, T_ABS, C_MT_TRACK, 100));
		send_item(raw_event(0, T_ABS, C_MT_POS_X, -5));
		send_item(raw_event(0, T_ABS, C_MT_POS_Y, 32'h7FFF_FFFF));
		send_item(raw_event(0, 5'd31, 10'd1023, 32'h8000_0000));
		send_item(raw_event(0, T_SYN, C_SYN_MT_REPORT, 0));
		send_item(raw_event(0, T_SYN, C_SYNC_FRAME, 0));
		// A touched slot that is not down still triggers a report.
		send_item(raw_event(7, T_ABS, C_MT_SLOT, SLOTS - 1));
		send_item(raw_event(7, T_ABS, C_MT_TOUCH_MAJOR, 32'h0000_FFFF));
		send_item(raw_event(7, T_SYN, C_SYNC_FRAME, 0));
		// The lift empties the table, so the release edges follow.
		send_item(raw_event(0, T_ABS, C_MT_TRACK, -1));
		send_item(raw_event(0, T_SYN, C_SYNC_FRAME, 0));
		wait_quiet();
	endtask

	// Injected down, move and up, with coordinate extremes and the ignored
	// slot numbers above the table.
	task automatic test_injections();
		send_item(inject_item(ACT_DOWN, 5, 0, 16'hFFFF, 16'h0000));
		send_item(inject_item(ACT_MOVE, 5, 0, 16'h1234, 16'hFFFF));
		send_item(inject_item(ACT_DOWN, 5, 15, 16'h0001, 16'h0001));
		send_item(inject_item(ACT_UP, 5, SLOTS, 16'h0000, 16'h0000));
		send_item(inject_item(ACT_DOWN, 2, 4, 16'd100, 16'd200));
		send_item(inject_item(ACT_UP, 5, 0, 16'h0000, 16'h0000));
		wait_quiet();
	endtask

	// With a zero inject scale, a down keeps the stored position and a move
	// clears it to zero.
	task automatic test_zero_inject_scale();
		load_scales(SCALE_ONE, SCALE_ONE, 24'd0);
		send_item(inject_item(ACT_DOWN, 2, 4, 16'hFFFF, 16'hFFFF));
		send_item(inject_item(ACT_MOVE, 2, 4, 16'hFFFF, 16'hFFFF));
		send_item(inject_item(ACT_UP, 2, 4, 16'h0000, 16'h0000));
		wait_quiet();
	endtask

	// Maximum x scale and zero y scale, under a slow receiver. Midway the
	// sender holds off until every report has drained.
	task automatic test_random_slow_receiver();
		src_idle_pct = 19;
		rcv_idle_pct = 62;
		load_scales(24'hFF_FFFF, 24'd0, 24'($urandom_range(24'h00_4000, 24'h02_0000)));
		run_random(22);
		wait_quiet();
		run_random(22);
		wait_quiet();
	endtask

	task automatic test_random_slow_sender();
		src_idle_pct = 62;
		rcv_idle_pct = 19;
		load_scales(24'($urandom_range(0, 24'h03_0000)), 24'($urandom_range(0, 24'h03_0000)),
			24'hFF_FFFF);
		run_random(42);
		wait_quiet();
	endtask

	task automatic test_random_full_rate();
		src_idle_pct = 0;
		rcv_idle_pct = 0;
		load_scales(24'($urandom_range(0, 24'h03_0000)), 24'($urandom_range(0, 24'h03_0000)),
			24'($urandom_range(0, 24'h03_0000)));
		run_random(42);
		wait_quiet();
	endtask

	// The checker compares every rpt transfer against the oldest queued
	// event; the always block below then sets the receiver's ready for the next cycle.
	task automatic check_event(input mt_event_t got);
		mt_event_t want;
		if (expected_events.size() == 0) begin
			errors++;
			if (errors <= MAX_PRINTS)
				$display("%0t: unexpected event type %0d code %0d value %0d last %0d",
					$realtime, got.out_type, got.out_code, got.out_value, got.last);
		end else begin
			want = expected_events.pop_front();
			if (got.out_type !== want.out_type || got.out_code !== want.out_code ||
					got.out_value !== want.out_value || got.last !== want.last) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display({"%0t: event mismatch: expected type %0d code %0d value %0d",
						" last %0d, actual type %0d code %0d value %0d last %0d"},
						$realtime, want.out_type, want.out_code, want.out_value, want.last,
						got.out_type, got.out_code, got.out_value, got.last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (rpt_valid && rpt_ready)
			check_event(rpt_data);
		rpt_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	// The watchdog counts cycles in which no transfer happens on either
	// channel.
	always @(posedge clk) begin
		if (!arst_n || (src_valid && src_ready) || (rpt_valid && rpt_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		foreach (pos_x_tab[i]) begin
			pos_x_tab[i] = '0;
			pos_y_tab[i] = '0;
			id_tab[i]    = '0;
			down_tab[i]  = 1'b0;
			touch_tab[i] = 1'b0;
		end
		foreach (cur_slot[i])
			cur_slot[i] = '0;
		src_idle_pct = 19;
		rcv_idle_pct = 62;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_raw_frames();
		test_injections();
		test_zero_inject_scale();
		test_random_slow_receiver();
		test_random_slow_sender();
		test_random_full_rate();

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
